// File: design/text_mode_console_writer_macros.svh
// Assertion macros used by the console writer checker
`ifndef TEXT_MODE_CONSOLE_WRITER_MACROS_SVH
`define TEXT_MODE_CONSOLE_WRITER_MACROS_SVH

// Same-cycle implication, sampled on clk, off while in reset
`define TMCW_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: check failed");

// Next-cycle implication
`define TMCW_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: check failed");

// Implication with a delayed consequent
`define TMCW_ASSERT_NEXT2(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> ##1 (cons)) \
        else $error("%m: check failed");

`endif

// File: design/tmcw_pkg.sv
// Shared constants and controller/datapath interface types for the console writer
package tmcw_pkg;

    // Operation codes
    localparam logic [1:0] OP_PUT   = 2'd0;
    localparam logic [1:0] OP_WRITE = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;

    // Character codes with special handling
    localparam logic [7:0] CH_TAB   = 8'd9;
    localparam logic [7:0] CH_LF    = 8'd10;
    localparam logic [7:0] CH_CR    = 8'd13;
    localparam logic [7:0] CH_SPACE = 8'd32;

    // Cursor register always uses an 80-column pitch
    localparam int CURSOR_PITCH = 80;
    localparam int TAB_STEP     = 4;

    localparam logic [15:0] CLEAR_CELL       = 16'h0720;
    localparam logic [7:0]  TEXT_COLOR_RESET = 8'h07;

    // Commands from controller to datapath
    typedef struct packed {
        logic load;   // latch a new item
        logic exec;   // carry out the latched item
        logic copy;   // scroll: move rows up
        logic blank;  // scroll: blank bottom row
        logic clear;  // screen clearing pass after reset
    } dp_cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic scroll;      // executing item needs a scroll
        logic copy_last;   // last step of the row copy
        logic blank_last;  // last step of the row blank
        logic clear_last;  // last step of the clearing pass
    } dp_status_t;

endpackage

// File: design/tmcw_ctrl.sv
// Controller state machine for the console writer
module tmcw_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  tmcw_pkg::dp_status_t status,
    output tmcw_pkg::dp_cmd_t    cmd,
    output logic                busy,
    output logic                done
);
    import tmcw_pkg::*;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_EXEC,
        S_COPY,
        S_BLANK,
        S_DONE
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   busy_reg;
    logic   busy_next;
    logic   done_reg;
    logic   done_next;
    logic   accept;

    // Sequence the clearing pass after reset and the phases of each item
    always_comb
    begin
        accept     = start && !busy_reg;
        state_next = state_reg;
        case (state_reg)
            S_CLEAR:
            begin
                if (status.clear_last)
                    state_next = S_IDLE;
            end
            S_IDLE, S_DONE:
            begin
                state_next = accept ? S_EXEC : S_IDLE;
            end
            S_EXEC:
            begin
                state_next = status.scroll ? S_COPY : S_DONE;
            end
            S_COPY:
            begin
                if (status.copy_last)
                    state_next = S_BLANK;
            end
            S_BLANK:
            begin
                if (status.blank_last)
                    state_next = S_DONE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
        busy_next = !(state_next == S_IDLE || state_next == S_DONE);
        done_next = (state_next == S_DONE);

        cmd.load  = accept;
        cmd.exec  = (state_reg == S_EXEC);
        cmd.copy  = (state_reg == S_COPY);
        cmd.blank = (state_reg == S_BLANK);
        cmd.clear = (state_reg == S_CLEAR);
    end

    // Hold state and registered handshake outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            busy_reg  <= 1'b1;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            busy_reg  <= busy_next;
            done_reg  <= done_next;
        end
    end

    assign busy = busy_reg;
    assign done = done_reg;

endmodule

// File: design/tmcw_datapath.sv
// Datapath of the console writer: screen memory, write position, cursor and colour
module tmcw_datapath #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  tmcw_pkg::dp_cmd_t    cmd,
    output tmcw_pkg::dp_status_t status,
    input  logic                 cfg_we,
    input  logic [7:0]           cfg_data,
    input  logic [1:0]           op,
    input  logic [7:0]           char_code,
    input  logic [7:0]           cell_color,
    input  logic [6:0]           target_column,
    input  logic [4:0]           target_row,
    output logic [15:0]          read_cell,
    output logic [10:0]          cursor_location,
    output logic [4:0]           cursor_row,
    output logic [6:0]           cursor_column
);
    import tmcw_pkg::*;

    localparam int CELLS = ROWS * COLUMNS;
    localparam int AW    = $clog2(CELLS);
    localparam int CNTW  = $clog2(CELLS + 1);
    localparam int RW    = $clog2(ROWS);
    localparam int CW    = $clog2(COLUMNS);

    localparam logic [AW-1:0]   COLS_A     = AW'(COLUMNS);
    localparam logic [CNTW-1:0] COLS_C     = CNTW'(COLUMNS);
    localparam logic [CNTW-1:0] COPY_END   = CNTW'(CELLS - COLUMNS);
    localparam logic [CNTW-1:0] BLANK_END  = CNTW'(CELLS);
    localparam logic [CNTW-1:0] CLEAR_END  = CNTW'(CELLS - 1);
    localparam logic [RW-1:0]   LAST_ROW   = RW'(ROWS - 1);

    // Screen memory
    logic [15:0] mem [CELLS];
    logic [15:0] mem_q_reg;
    logic        mem_we;
    logic [AW-1:0] mem_wa;
    logic [15:0] mem_wd;
    logic        mem_re;
    logic [AW-1:0] mem_ra;

    // Latched item
    logic [1:0]  op_reg;
    logic [7:0]  char_reg;
    logic [7:0]  attr_reg;
    logic [6:0]  tcol_reg;
    logic [4:0]  trow_reg;

    // Position, cursor, colour, sweep counter
    logic [RW-1:0]   row_reg;
    logic [RW-1:0]   row_next;
    logic [CW-1:0]   col_reg;
    logic [CW-1:0]   col_next;
    logic [10:0]     cursor_reg;
    logic [10:0]     cursor_next;
    logic [7:0]      color_reg;
    logic [CNTW-1:0] cnt_reg;
    logic            rd_flag_reg;
    logic            rd_flag_next;

    logic          is_nl;
    logic          is_tab;
    logic          is_prt;
    logic          in_range;
    logic          line_end;
    logic          row_over;
    logic          upd_cursor;
    logic [CW:0]   col_inc;
    logic [CW:0]   col_tab;
    logic [RW:0]   row_inc;
    logic [AW-1:0] pos_addr;
    logic [AW-1:0] tgt_addr;
    logic [CNTW-1:0] cnt_rd;
    logic [CNTW-1:0] cnt_wr;

    // Decode the latched item and work out the new position
    always_comb
    begin
        is_nl    = (op_reg == OP_PUT) && (char_reg == CH_LF || char_reg == CH_CR);
        is_tab   = (op_reg == OP_PUT) && (char_reg == CH_TAB);
        is_prt   = (op_reg == OP_PUT) && !is_nl && !is_tab;
        in_range = (32'(tcol_reg) < COLUMNS) && (32'(trow_reg) < ROWS);

        col_inc  = (CW+1)'(col_reg) + (CW+1)'(1);
        col_tab  = (CW+1)'(col_reg) + (CW+1)'(TAB_STEP);
        row_inc  = (RW+1)'(row_reg) + (RW+1)'(1);
        row_over = (32'(row_inc) >= ROWS);
        line_end = is_nl || (is_prt && (32'(col_inc) >= COLUMNS));

        row_next   = row_reg;
        col_next   = col_reg;
        upd_cursor = 1'b0;
        if (line_end)
        begin
            col_next   = '0;
            row_next   = row_over ? LAST_ROW : RW'(row_inc);
            upd_cursor = 1'b1;
        end
        else if (is_prt)
        begin
            col_next   = CW'(col_inc);
            upd_cursor = 1'b1;
        end
        else if (is_tab)
        begin
            if (32'(col_tab) >= COLUMNS)
            begin
                col_next = '0;
                row_next = row_over ? '0 : RW'(row_inc);
            end
            else
            begin
                col_next = CW'(col_tab);
            end
        end

        cursor_next  = upd_cursor
                     ? 11'(32'(row_next) * CURSOR_PITCH + 32'(col_next))
                     : cursor_reg;
        rd_flag_next = (op_reg == OP_READ) && in_range;

        pos_addr = AW'(row_reg) * COLS_A + AW'(col_reg);
        tgt_addr = AW'(trow_reg) * COLS_A + AW'(tcol_reg);

        status.scroll     = line_end && row_over;
        status.copy_last  = (cnt_reg == COPY_END);
        status.blank_last = (cnt_reg == BLANK_END);
        status.clear_last = (cnt_reg == CLEAR_END);
    end

    // Select the memory ports for the active phase
    always_comb
    begin
        cnt_rd = cnt_reg + COLS_C;
        cnt_wr = cnt_reg - CNTW'(1);
        mem_we = 1'b0;
        mem_wa = '0;
        mem_wd = '0;
        mem_re = 1'b0;
        mem_ra = '0;
        if (cmd.clear)
        begin
            mem_we = 1'b1;
            mem_wa = cnt_reg[AW-1:0];
            mem_wd = CLEAR_CELL;
        end
        else if (cmd.exec)
        begin
            if (is_prt)
            begin
                mem_we = 1'b1;
                mem_wa = pos_addr;
                mem_wd = {color_reg, char_reg};
            end
            else if (op_reg == OP_WRITE && in_range)
            begin
                mem_we = 1'b1;
                mem_wa = tgt_addr;
                mem_wd = {attr_reg, char_reg};
            end
            mem_re = rd_flag_next;
            mem_ra = tgt_addr;
        end
        else if (cmd.copy)
        begin
            // Read one row ahead, write the beat read on the cycle before
            mem_re = (cnt_reg < COPY_END);
            mem_ra = cnt_rd[AW-1:0];
            mem_we = (cnt_reg != '0);
            mem_wa = cnt_wr[AW-1:0];
            mem_wd = mem_q_reg;
        end
        else if (cmd.blank)
        begin
            mem_we = 1'b1;
            mem_wa = cnt_wr[AW-1:0];
            mem_wd = {color_reg, CH_SPACE};
        end
    end

    // Screen memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_wa] <= mem_wd;
        if (mem_re)
            mem_q_reg <= mem[mem_ra];
    end

    // Latch the item fields on acceptance
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg   <= op;
            char_reg <= char_code;
            attr_reg <= cell_color;
            tcol_reg <= target_column;
            trow_reg <= target_row;
        end
    end

    // Update position, cursor, colour and sweep counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg     <= '0;
            col_reg     <= '0;
            cursor_reg  <= '0;
            color_reg   <= TEXT_COLOR_RESET;
            cnt_reg     <= '0;
            rd_flag_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
                color_reg <= cfg_data;
            if (cmd.exec)
            begin
                row_reg     <= row_next;
                col_reg     <= col_next;
                cursor_reg  <= cursor_next;
                rd_flag_reg <= rd_flag_next;
                cnt_reg     <= '0;
            end
            else if (cmd.copy || cmd.blank || cmd.clear)
            begin
                cnt_reg <= cnt_reg + CNTW'(1);
            end
        end
    end

    assign read_cell       = rd_flag_reg ? mem_q_reg : 16'h0000;
    assign cursor_location = cursor_reg;
    assign cursor_row      = 5'(row_reg);
    assign cursor_column   = 7'(col_reg);

endmodule

// File: design/text_mode_console_writer.sv
// Top level of the text-mode console writer
//
//  channel   | handshake               | beat contents
//  ----------+-------------------------+------------------------------------------
//  command   | start / busy            | op, char_code, cell_color, target_column,
//            |                         | target_row
//  result    | done (one-cycle strobe) | read_cell, cursor_location, cursor_row,
//            |                         | cursor_column
//  config    | cfg_valid / cfg_ready   | cfg_data (text colour)
//
// Each command passes through an execute state, doing at most one memory read
// or write, then the result state, in which the next command is taken.
// A scroll adds the row copy and the bottom-row blank: the row copy runs one
// cell per cycle through the one read and one write port of the screen memory.
// After reset busy stays high while the clearing pass fills the screen;
// config beats are taken throughout.
// The result strobe cannot be held off; cfg_ready is always high.
module text_mode_console_writer #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  op,
    input  logic [7:0]  char_code,
    input  logic [7:0]  cell_color,
    input  logic [6:0]  target_column,
    input  logic [4:0]  target_row,
    output logic        done,
    output logic [15:0] read_cell,
    output logic [10:0] cursor_location,
    output logic [4:0]  cursor_row,
    output logic [6:0]  cursor_column,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_data
);
    import tmcw_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;

    assign cfg_ready = 1'b1;

    // Controller
    tmcw_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .cmd    (cmd),
        .busy   (busy),
        .done   (done)
    );

    // Datapath
    tmcw_datapath #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .status          (status),
        .cfg_we          (cfg_valid && cfg_ready),
        .cfg_data        (cfg_data),
        .op              (op),
        .char_code       (char_code),
        .cell_color      (cell_color),
        .target_column   (target_column),
        .target_row      (target_row),
        .read_cell       (read_cell),
        .cursor_location (cursor_location),
        .cursor_row      (cursor_row),
        .cursor_column   (cursor_column)
    );

endmodule

// File: design/tmcw_checker.sv
// Port-level checks on the console writer and their binding to the top level
`include "text_mode_console_writer_macros.svh"

module tmcw_checker #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input logic       clk,
    input logic       rst_n,
    input logic       start,
    input logic       busy,
    input logic       done,
    input logic [4:0] cursor_row,
    input logic [6:0] cursor_column
);

    // An accepted command raises busy in the cycle after, blocking the next beat
    `TMCW_ASSERT_NEXT(a_accept_busy, start && !busy, busy)

    // After the execute state, the result is out or a scroll is running
    `TMCW_ASSERT_NEXT2(a_accept_result, start && !busy, done || busy)

    // Each result is strobed for one cycle only
    `TMCW_ASSERT_NEXT(a_done_single, done, !done)

    // Reported write position lies on the screen
    `TMCW_ASSERT_NOW(a_pos_range, done,
                     (32'(cursor_column) < COLUMNS) && (32'(cursor_row) < ROWS))

endmodule

bind text_mode_console_writer tmcw_checker #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
) u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .done          (done),
    .cursor_row    (cursor_row),
    .cursor_column (cursor_column)
);
